// ----- hdl/lgt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

  // Grid size limits used as defaults for the top level parameters.
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 32;

  // Field and register widths.
  localparam int SIZE_W  = 7;
  localparam int MODE_W  = 2;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int CFG_W   = 7;
  localparam int ROWS_W  = 6;
  localparam int CIDX_REG_W = 1;

  // Reset values of the size registers.
  localparam logic [SIZE_W-1:0] COLS_RESET = 7'd60;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd20;

  // Configuration register indexes.
  localparam logic [CIDX_REG_W-1:0] REG_COLS = 1'b0;
  localparam logic [CIDX_REG_W-1:0] REG_ROWS = 1'b1;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GEN    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Operations broadcast to every column cell.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_STEP   = 3'd4;

  // Control word shared by all column cells.
  typedef struct packed {
    logic [2:0] op;
    logic       wr_bit;
    logic       last_row;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lgt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One grid column. Holds every row of its column and a three-row window
// (row above, current row, row below) that it shares with both neighbors
// during a generation pass.
module lgt_cell #(
  parameter int MAX_ROWS = lgt_pkg::DEF_MAX_ROWS,
  parameter int RIDX_W   = $clog2(MAX_ROWS)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  lgt_pkg::cell_ctrl_t ctrl,
  input  wire                 sel,
  input  wire                 active,
  input  wire  [RIDX_W-1:0]   acc_row,
  input  wire  [RIDX_W-1:0]   rd_row,
  input  wire  [RIDX_W-1:0]   wr_row,
  input  wire  [2:0]          nbr_left,
  input  wire  [2:0]          nbr_right,
  output logic [2:0]          win,
  output logic                acc_bit
);
  import lgt_pkg::*;

  logic [MAX_ROWS-1:0] column;
  logic                prev;
  logic                cur;
  logic                first;
  logic                below;
  logic [3:0]          count;
  logic                life;

  // The row below wraps to the saved copy of the old first row.
  assign below   = ctrl.last_row ? first : column[rd_row];
  assign win     = {below, cur, prev};
  assign acc_bit = column[acc_row];

  // Live neighbor count over the eight wrapped positions.
  assign count = 4'(nbr_left[0]) + 4'(nbr_left[1]) + 4'(nbr_left[2])
               + 4'(nbr_right[0]) + 4'(nbr_right[1]) + 4'(nbr_right[2])
               + 4'(prev) + 4'(below);

  // Rule B3/S23.
  assign life = (count == 4'd3) || (cur && (count == 4'd2));

  // Column storage and window registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      prev   <= 1'b0;
      cur    <= 1'b0;
      first  <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_WRITE: begin
          if (sel) column[acc_row] <= ctrl.wr_bit;
        end
        OP_TOGGLE: begin
          if (sel) column[acc_row] <= ~column[acc_row];
        end
        OP_LOAD: begin
          prev  <= column[rd_row];
          cur   <= column[0];
          first <= column[0];
        end
        OP_STEP: begin
          if (active) column[wr_row] <= life;
          prev <= cur;
          cur  <= below;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/life_generation_torus_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Game of Life (B3/S23) on a wrapped grid of up to MAX_COLS x MAX_ROWS cells.
// Requests enter on req_valid/req_stall with mode, col, row and cell_in; each
// request gives exactly one result on res_valid/res_stall with cell_out and
// status. Write, toggle and read requests finish at the accepting edge and
// their result is shown in the next cycle, so they run one per cycle while
// the receiver does not stall and no generation pass runs. A generation
// request holds the input while the column cells load the wrap rows and then
// through the row-serial pass along the chain of column cells. Its result
// (0, ok) is loaded at the edge that writes the last row, or later if the
// receiver stalls. cols_in_use and rows_in_use are written on cfg_we, cfg_index
// and cfg_data while the block is idle, a rule for the user that the block
// does not enforce; a size of 0 acts as 1 and sizes above the maximum clamp.
// Reset clears the whole grid, sets the size to 60 x 20 and empties the result
// register. While the receiver stalls, the result holds; a further cell
// request waits, and a generation request may start and then waits at its end.
module life_generation_torus_core #(
  parameter int MAX_COLS = lgt_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lgt_pkg::DEF_MAX_ROWS
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               req_valid,
  output logic                              req_stall,
  input  wire  [lgt_pkg::MODE_W-1:0]        mode,
  input  wire  [lgt_pkg::COL_W-1:0]         col,
  input  wire  [lgt_pkg::ROW_W-1:0]         row,
  input  wire                               cell_in,
  output logic                              res_valid,
  input  wire                               res_stall,
  output logic                              cell_out,
  output logic                              status,
  input  wire                               cfg_we,
  input  wire  [lgt_pkg::CIDX_REG_W-1:0]    cfg_index,
  input  wire  [lgt_pkg::CFG_W-1:0]         cfg_data
);
  import lgt_pkg::*;

  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int RIDX_W = $clog2(MAX_ROWS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [SIZE_W-1:0] cols_in_use;
  logic [ROWS_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] wm1;
  logic [SIZE_W-1:0] hm1;

  logic [1:0]        state;
  logic [RIDX_W-1:0] y;
  logic              y_last;
  logic              in_range;
  logic              req_acc;
  logic              res_free;
  logic              load_cell;
  logic              load_gen;
  logic              old_bit;
  logic              cell_out_next;

  cell_ctrl_t        ctrl;
  logic [RIDX_W-1:0] acc_row;
  logic [RIDX_W-1:0] rd_row;
  logic [2:0]        win [MAX_COLS];
  logic [2:0]        nbr_l [MAX_COLS];
  logic [2:0]        nbr_r [MAX_COLS];
  logic [MAX_COLS-1:0] acc_bits;

  // Effective sizes with the clamps applied.
  always_comb begin
    if (cols_in_use == '0) w_eff = SIZE_W'(1);
    else if (cols_in_use > SIZE_W'(MAX_COLS)) w_eff = SIZE_W'(MAX_COLS);
    else w_eff = cols_in_use;
    if (rows_in_use == '0) h_eff = SIZE_W'(1);
    else if (SIZE_W'(rows_in_use) > SIZE_W'(MAX_ROWS)) h_eff = SIZE_W'(MAX_ROWS);
    else h_eff = SIZE_W'(rows_in_use);
  end

  assign wm1 = w_eff - SIZE_W'(1);
  assign hm1 = h_eff - SIZE_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: cols_in_use <= cfg_data;
        REG_ROWS: rows_in_use <= cfg_data[ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request handshake.
  assign res_free  = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE) || (!res_free && (mode != MODE_GEN));
  assign req_acc   = req_valid && !req_stall;
  assign in_range  = (SIZE_W'(col) < w_eff) && (SIZE_W'(row) < h_eff);
  assign y_last    = (SIZE_W'(y) == hm1);
  assign acc_row   = RIDX_W'(row);
  assign rd_row    = (state == ST_LOAD) ? hm1[RIDX_W-1:0] : y + RIDX_W'(1);

  // Control word for the column cells.
  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && in_range && (mode == MODE_WRITE)) begin
          ctrl.op     = OP_WRITE;
          ctrl.wr_bit = cell_in;
        end else if (req_acc && in_range && (mode == MODE_TOGGLE)) begin
          ctrl.op = OP_TOGGLE;
        end
      end
      ST_LOAD: ctrl.op = OP_LOAD;
      ST_STEP: begin
        ctrl.op       = OP_STEP;
        ctrl.last_row = y_last;
      end
      default: begin
      end
    endcase
  end

  // Chain of column cells with wraparound at the column in use.
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic is_last;
    assign is_last = (wm1[CIDX_W-1:0] == CIDX_W'(c));

    if (c == 0) begin : g_left_wrap
      assign nbr_l[c] = win[wm1[CIDX_W-1:0]];
    end else begin : g_left
      assign nbr_l[c] = win[c-1];
    end

    // The last column of the grid in use sees column 0 on its right.
    assign nbr_r[c] = is_last ? win[0] : win[(c + 1) % MAX_COLS];

    lgt_cell #(
      .MAX_ROWS(MAX_ROWS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (SIZE_W'(col) == SIZE_W'(c)),
      .active   (SIZE_W'(c) < w_eff),
      .acc_row  (acc_row),
      .rd_row   (rd_row),
      .wr_row   (y),
      .nbr_left (nbr_l[c]),
      .nbr_right(nbr_r[c]),
      .win      (win[c]),
      .acc_bit  (acc_bits[c])
    );
  end

  // Result of a cell request, from the value before the update.
  assign old_bit = acc_bits[col[CIDX_W-1:0]];

  always_comb begin
    cell_out_next = 1'b0;
    if (in_range) begin
      case (mode)
        MODE_WRITE:  cell_out_next = cell_in;
        MODE_TOGGLE: cell_out_next = ~old_bit;
        default:     cell_out_next = old_bit;
      endcase
    end
  end

  // Sequencer for the generation pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      y     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_acc && (mode == MODE_GEN)) state <= ST_LOAD;
        end
        ST_LOAD: begin
          y     <= '0;
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (y_last) begin
            state <= res_free ? ST_IDLE : ST_DONE;
          end else begin
            y <= y + RIDX_W'(1);
          end
        end
        ST_DONE: begin
          if (res_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register.
  assign load_cell = req_acc && (mode != MODE_GEN);
  assign load_gen  = res_free && (((state == ST_STEP) && y_last) || (state == ST_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_cell || load_gen) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cell) begin
      cell_out <= cell_out_next;
      status   <= !in_range;
    end else if (load_gen) begin
      cell_out <= 1'b0;
      status   <= 1'b0;
    end
  end

`ifndef SYNTH
  // A generation request always starts with the wrap-row load.
  a_gen_load: assert property (@(posedge clk) disable iff (rst)
    req_acc && (mode == MODE_GEN) |=> state == ST_LOAD)
    else $error("generation request did not enter load");

  // A cell request outside the grid reports a range error and a dead cell.
  a_range_err: assert property (@(posedge clk) disable iff (rst)
    req_acc && (mode != MODE_GEN) && !in_range |=> res_valid && status && !cell_out)
    else $error("out of range request gave wrong result");

  // Requests are only taken while the sequencer is idle.
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> state == ST_IDLE)
    else $error("request accepted during generation pass");

  // The row counter never passes the rows in use.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> SIZE_W'(y) < h_eff)
    else $error("row counter beyond rows in use");

  // The pass keeps stepping until the last row.
  a_step_cont: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) && !y_last |=> state == ST_STEP)
    else $error("generation pass left early");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lgt_pkg::*;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 32;
  localparam int STUCK_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1730;
  localparam int N_SIZES = 16;
  localparam int REPORT_CAP = 100;

  // One request as the sender presents it.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              cell_in;
  } life_req_t;

  // One result as the receiver sees it.
  typedef struct packed {
    logic cell_out;
    logic status;
  } cell_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [MODE_W-1:0]     mode = MODE_READ;
  logic [COL_W-1:0]      col = '0;
  logic [ROW_W-1:0]      row = '0;
  logic                  cell_in = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  cell_out;
  logic                  status;
  logic                  cfg_we = 1'b0;
  logic [CIDX_REG_W-1:0] cfg_index = REG_COLS;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Shadow copy of the grid and the size registers.
  logic [GRID_COLS-1:0] grid_model [GRID_ROWS];
  logic [SIZE_W-1:0]    cols_model = COLS_RESET;
  logic [ROWS_W-1:0]    rows_model = ROWS_RESET;

  life_req_t    pending_reqs[$];
  cell_result_t expected_results[$];

  int n_accepted = 0;
  int n_generations = 0;
  int n_out_of_range = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_settings = 0;
  int stuck_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_tick = 0;
  life_req_t    drive_req;
  cell_result_t want;

  // Size plan: full grid size first, then extremes, clamps and odd sizes.
  int plan_cols[N_SIZES] = '{64, 1, 2, 3, 2, 127, 0, 64, 1, 8, 17, 33, 60, 0, 0, 0};
  int plan_rows[N_SIZES] = '{32, 1, 2, 3, 5, 63, 0, 1, 32, 8, 11, 20, 20, 0, 0, 0};

  life_generation_torus_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .col       (col),
    .row       (row),
    .cell_in   (cell_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cell_out  (cell_out),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective sizes: zero acts as one, large values clamp to the grid.
  function automatic int used_cols();
    if (cols_model == 0) return 1;
    if (cols_model > GRID_COLS) return GRID_COLS;
    return int'(cols_model);
  endfunction

  function automatic int used_rows();
    if (rows_model == 0) return 1;
    if (rows_model > GRID_ROWS) return GRID_ROWS;
    return int'(rows_model);
  endfunction

  // One B3/S23 generation inside the used area, computed from a snapshot of
  // the old grid. Wrapped neighbor positions that coincide count separately.
  task automatic advance_generation();
    logic [GRID_COLS-1:0] old_gen [GRID_ROWS];
    int w, h, n;
    int rs[3];
    int cs[3];
    w = used_cols();
    h = used_rows();
    old_gen = grid_model;
    for (int y = 0; y < h; y++) begin
      rs = '{(y + h - 1) % h, y, (y + 1) % h};
      for (int x = 0; x < w; x++) begin
        cs = '{(x + w - 1) % w, x, (x + 1) % w};
        n = 0;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1)) n = n + old_gen[rs[i]][cs[j]];
          end
        end
        if (old_gen[y][x]) grid_model[y][x] = (n == 2 || n == 3);
        else grid_model[y][x] = (n == 3);
      end
    end
  endtask

  // Applies one accepted request to the shadow grid and queues its result.
  task automatic predict_request(life_req_t rq);
    cell_result_t res;
    res = '0;
    if (rq.mode == MODE_GEN) begin
      advance_generation();
      n_generations++;
    end else if (rq.col >= used_cols() || rq.row >= used_rows()) begin
      res.status = 1'b1;
      n_out_of_range++;
    end else begin
      if (rq.mode == MODE_WRITE) begin
        grid_model[rq.row][rq.col] = rq.cell_in;
      end else if (rq.mode == MODE_TOGGLE) begin
        grid_model[rq.row][rq.col] = ~grid_model[rq.row][rq.col];
      end
      res.cell_out = grid_model[rq.row][rq.col];
    end
    expected_results.push_back(res);
  endtask

  task automatic queue_req(logic [MODE_W-1:0] m, int c, int r, logic ci);
    pending_reqs.push_back(life_req_t'{m, COL_W'(c), ROW_W'(r), ci});
  endtask

  // Returns at a falling edge once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
  endtask

  // Writes both size registers while the block is idle.
  task automatic set_grid_size(int cols_val, int rows_val);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLS;
    cfg_data <= CFG_W'(cols_val);
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= CFG_W'(rows_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    cols_model = SIZE_W'(cols_val);
    rows_model = ROWS_W'(rows_val);
    n_settings++;
  endtask

  // Mostly seeded patterns followed by generations and reads, with some
  // scattered writes and toggles and some fully random noise.
  task automatic random_phase(int n_items);
    int w, h, k, c0, r0, left;
    w = used_cols();
    h = used_rows();
    left = n_items;
    @(negedge clk);
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_req(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                    $urandom_range(0, 31), 1'($urandom_range(0, 1)));
          left--;
        end
        2: begin
          k = $urandom_range(1, 6);
          for (int i = 0; i < k; i++) begin
            queue_req($urandom_range(0, 1) ? MODE_TOGGLE : MODE_WRITE,
                      $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                      1'($urandom_range(0, 1)));
          end
          left -= k;
        end
        default: begin
          c0 = $urandom_range(0, w - 1);
          r0 = $urandom_range(0, h - 1);
          k = $urandom_range(2, 10);
          for (int i = 0; i < k; i++) begin
            queue_req(MODE_WRITE, (c0 + $urandom_range(0, 3)) % w,
                      (r0 + $urandom_range(0, 3)) % h, $urandom_range(0, 3) != 0);
          end
          left -= k;
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) queue_req(MODE_GEN, $urandom_range(0, 63),
                                                $urandom_range(0, 31), 1'($urandom_range(0, 1)));
          left -= k;
          k = $urandom_range(2, 8);
          for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              queue_req(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 31), 1'b0);
            end else begin
              queue_req(MODE_READ, (c0 + $urandom_range(0, 4)) % w,
                        (r0 + $urandom_range(0, 4)) % h, 1'b0);
            end
          end
          left -= k;
        end
      endcase
    end
  endtask

  // Sender: bursts of random length with random gaps; holds while stalled.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_request(life_req_t'({mode, col, row, cell_in}));
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drive_req = pending_reqs.pop_front();
          mode <= drive_req.mode;
          col <= drive_req.col;
          row <= drive_req.row;
          cell_in <= drive_req.cell_in;
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: free running, random, periodic, long stretches.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      case (stall_tick[9:8])
        2'd0: res_stall <= 1'b0;
        2'd1: res_stall <= ($urandom_range(0, 1) == 1);
        2'd2: res_stall <= (stall_tick[1:0] == 2'd0);
        default: res_stall <= stall_tick[3];
      endcase
    end
  end

  // Result checker against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_CAP) begin
          $display("%0t: unexpected result, expected none, got cell_out %0b status %0b",
                   $time, cell_out, status);
        end
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (cell_out !== want.cell_out) begin
          n_errors++;
          if (n_errors <= REPORT_CAP) begin
            $display("%0t: cell_out mismatch, expected %0b, got %0b",
                     $time, want.cell_out, cell_out);
          end
        end
        if (status !== want.status) begin
          n_errors++;
          if (n_errors <= REPORT_CAP) begin
            $display("%0t: status mismatch, expected %0b, got %0b",
                     $time, want.status, status);
          end
        end
      end
    end
  end

  // Counts cycles with work outstanding but no handshake on either side.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      stuck_cycles <= 0;
    end else if (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0) begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t: no progress for %0d cycles, %0d results outstanding",
             $time, STUCK_LIMIT, expected_results.size());
    $display("[life_generation_torus_core] ERROR");
    $finish;
  end

  initial begin
    for (int r = 0; r < GRID_ROWS; r++) grid_model[r] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset size of 60 x 20: corners, toggles, range
    // errors on each coordinate, and a blinker straddling both wrap seams.
    queue_req(MODE_WRITE, 0, 0, 1'b1);
    queue_req(MODE_READ, 0, 0, 1'b0);
    queue_req(MODE_WRITE, 59, 19, 1'b1);
    queue_req(MODE_TOGGLE, 59, 19, 1'b0);
    queue_req(MODE_TOGGLE, 59, 19, 1'b1);
    queue_req(MODE_WRITE, 59, 19, 1'b0);
    queue_req(MODE_READ, 59, 19, 1'b0);
    queue_req(MODE_WRITE, 60, 0, 1'b1);
    queue_req(MODE_TOGGLE, 0, 20, 1'b0);
    queue_req(MODE_READ, 63, 31, 1'b1);
    queue_req(MODE_READ, 59, 20, 1'b0);
    queue_req(MODE_WRITE, 63, 31, 1'b1);
    queue_req(MODE_WRITE, 59, 0, 1'b1);
    queue_req(MODE_WRITE, 1, 0, 1'b1);
    queue_req(MODE_GEN, 0, 0, 1'b0);
    queue_req(MODE_READ, 0, 19, 1'b0);
    queue_req(MODE_READ, 0, 1, 1'b0);
    queue_req(MODE_READ, 59, 0, 1'b0);
    queue_req(MODE_GEN, 63, 31, 1'b1);
    queue_req(MODE_READ, 59, 0, 1'b0);
    queue_req(MODE_READ, 0, 19, 1'b0);

    random_phase(RANDOM_ITEMS / (N_SIZES + 1));
    for (int i = 0; i < N_SIZES; i++) begin
      if (plan_cols[i] == 0 && plan_rows[i] == 0 && i >= 13) begin
        set_grid_size($urandom_range(3, 64), $urandom_range(3, 32));
      end else begin
        set_grid_size(plan_cols[i], plan_rows[i]);
      end
      random_phase(RANDOM_ITEMS / (N_SIZES + 1));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Ran %0d requests over %0d grid sizes: %0d generation steps, %0d outside the grid.",
             n_accepted, n_settings + 1, n_generations, n_out_of_range);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("[life_generation_torus_core] OK");
    end else begin
      $display("[life_generation_torus_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lgt_pkg.sv
hdl/lgt_cell.sv
hdl/life_generation_torus_core.sv
bench/tb_top.sv
